@@ rtl/tbse_pkg.sv @@
// shared types and constants for the triple buffer slot exchange
// no dependencies, compiled first
package tbse_pkg;

    localparam int NUM_SLOTS = 3;
    localparam int SEQ_WIDTH = 32;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 2;
    localparam int REQ_SEQ_W = 32;
    localparam int DROP_W    = 32;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_WRITING = 2'd1,
        ST_READY   = 2'd2,
        ST_READING = 2'd3
    } slot_state_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN_WRITE = 3'd0,
        CMD_PUBLISH     = 3'd1,
        CMD_ABANDON     = 3'd2,
        CMD_ACQUIRE     = 3'd3,
        CMD_RELEASE     = 3'd4
    } cmd_t;

    typedef logic [SLOT_W-1:0]    slot_idx_t;
    typedef logic [SEQ_WIDTH-1:0] seq_t;

    // slot choices offered to the command decode
    typedef struct packed {
        logic      free_found;
        slot_idx_t free_idx;
        logic      oldest_found;
        slot_idx_t oldest_idx;
        logic      newest_found;
        slot_idx_t newest_idx;
    } pick_t;

endpackage

@@ rtl/tbse_cmd_if.sv @@
// command channel: valid/ready with the command item payload
// depends on tbse_pkg
interface tbse_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [tbse_pkg::CMD_W-1:0]     command;
    logic [tbse_pkg::IDX_W-1:0]     slot_index;
    logic [tbse_pkg::REQ_SEQ_W-1:0] sequence_req;

    modport source (output valid, command, slot_index, sequence_req, input ready);
    modport sink   (input valid, command, slot_index, sequence_req, output ready);
endinterface

@@ rtl/tbse_res_if.sv @@
// result channel: valid/ready with the result item payload
// depends on tbse_pkg
interface tbse_res_if;
    logic                        valid;
    logic                        ready;
    logic                        write_granted;
    logic [tbse_pkg::IDX_W-1:0]  write_slot;
    logic                        holds_previous;
    logic [tbse_pkg::IDX_W-1:0]  previous_slot;
    logic                        holds_current;
    logic [tbse_pkg::IDX_W-1:0]  current_slot;
    logic                        new_snapshot;
    logic [tbse_pkg::DROP_W-1:0] dropped_count;

    modport source (output valid, write_granted, write_slot, holds_previous, previous_slot,
                    holds_current, current_slot, new_snapshot, dropped_count, input ready);
    modport sink   (input valid, write_granted, write_slot, holds_previous, previous_slot,
                    holds_current, current_slot, new_snapshot, dropped_count, output ready);
endinterface

@@ rtl/tbse_select.sv @@
// slot pickers: lowest free, oldest ready and newest ready slot
// depends on tbse_pkg
module tbse_select (
    input  tbse_pkg::slot_state_t [tbse_pkg::NUM_SLOTS-1:0] status,
    input  tbse_pkg::seq_t        [tbse_pkg::NUM_SLOTS-1:0] seq,
    output tbse_pkg::pick_t                                 pick
);

    tbse_pkg::seq_t oldest_seq;
    tbse_pkg::seq_t newest_seq;

    // strict compares keep the lower index on equal sequences
    always_comb
    begin
        pick       = '0;
        oldest_seq = '0;
        newest_seq = '0;
        for (int i = 0; i < tbse_pkg::NUM_SLOTS; i++)
        begin
            if (status[i] == tbse_pkg::ST_FREE && !pick.free_found)
            begin
                pick.free_found = 1'b1;
                pick.free_idx   = tbse_pkg::SLOT_W'(i);
            end
            if (status[i] == tbse_pkg::ST_READY)
            begin
                if (!pick.oldest_found || seq[i] < oldest_seq)
                begin
                    pick.oldest_found = 1'b1;
                    pick.oldest_idx   = tbse_pkg::SLOT_W'(i);
                    oldest_seq        = seq[i];
                end
                if (!pick.newest_found || seq[i] > newest_seq)
                begin
                    pick.newest_found = 1'b1;
                    pick.newest_idx   = tbse_pkg::SLOT_W'(i);
                    newest_seq        = seq[i];
                end
            end
        end
    end

endmodule

@@ rtl/triple_buffer_slot_exchange_top.sv @@
// triple buffer slot exchange: the command passes the input register, then the result
// register, before the result item is valid; one command per cycle is sustained
// while the result side keeps ready high, the slot pickers being the only deep logic
// rst_n clears all slots to free, sequences and the drop count to zero, and empties both
// pipeline registers; depends on tbse_pkg, tbse_cmd_if, tbse_res_if and tbse_select
module triple_buffer_slot_exchange_top (
    input  logic       clk,
    input  logic       rst_n,
    tbse_cmd_if.sink   cmd,
    tbse_res_if.source res
);

    // input register stage
    logic                           in_valid_reg;
    tbse_pkg::cmd_t                 in_cmd_reg;
    logic [tbse_pkg::IDX_W-1:0]     in_sel_reg;
    logic [tbse_pkg::REQ_SEQ_W-1:0] in_seq_reg;

    // slot and consumer state
    tbse_pkg::slot_state_t [tbse_pkg::NUM_SLOTS-1:0] status_reg;
    tbse_pkg::slot_state_t [tbse_pkg::NUM_SLOTS-1:0] status_next;
    tbse_pkg::seq_t        [tbse_pkg::NUM_SLOTS-1:0] seq_reg;
    tbse_pkg::seq_t        [tbse_pkg::NUM_SLOTS-1:0] seq_next;
    logic [tbse_pkg::DROP_W-1:0] drop_reg;
    logic [tbse_pkg::DROP_W-1:0] drop_next;
    logic                        prev_valid_reg;
    logic                        prev_valid_next;
    tbse_pkg::slot_idx_t         prev_idx_reg;
    tbse_pkg::slot_idx_t         prev_idx_next;
    logic                        cur_valid_reg;
    logic                        cur_valid_next;
    tbse_pkg::slot_idx_t         cur_idx_reg;
    tbse_pkg::slot_idx_t         cur_idx_next;

    // per-command result bits
    logic                granted;
    tbse_pkg::slot_idx_t gslot;
    logic                fresh;
    logic                sel_ok;
    tbse_pkg::slot_idx_t sel_idx;

    // result register stage
    logic                        out_valid_reg;
    logic                        out_granted_reg;
    logic [tbse_pkg::IDX_W-1:0]  out_wslot_reg;
    logic                        out_has_prev_reg;
    logic [tbse_pkg::IDX_W-1:0]  out_prev_reg;
    logic                        out_has_cur_reg;
    logic [tbse_pkg::IDX_W-1:0]  out_cur_reg;
    logic                        out_fresh_reg;
    logic [tbse_pkg::DROP_W-1:0] out_drop_reg;

    tbse_pkg::pick_t pick;
    logic            process;
    logic            in_take;

    // the held item is executed once the result register is empty or being drained;
    // the input register refills in the same cycle so items stream back to back
    assign process    = in_valid_reg && (!out_valid_reg || res.ready);
    assign in_take    = cmd.valid && cmd.ready;
    assign cmd.ready  = !in_valid_reg || process;

    tbse_select u_select (
        .status (status_reg),
        .seq    (seq_reg),
        .pick   (pick)
    );

    // slot_index beyond the slot count names nothing
    assign sel_ok  = (32'(in_sel_reg) < 32'(tbse_pkg::NUM_SLOTS));
    assign sel_idx = tbse_pkg::SLOT_W'(in_sel_reg);

    // command decode and next state
    always_comb
    begin
        status_next     = status_reg;
        seq_next        = seq_reg;
        drop_next       = drop_reg;
        prev_valid_next = prev_valid_reg;
        prev_idx_next   = prev_idx_reg;
        cur_valid_next  = cur_valid_reg;
        cur_idx_next    = cur_idx_reg;
        granted         = 1'b0;
        gslot           = '0;
        fresh           = 1'b0;
        case (in_cmd_reg) inside
            tbse_pkg::CMD_BEGIN_WRITE:
            begin
                // a free slot first, otherwise evict the oldest ready snapshot
                if (pick.free_found)
                begin
                    status_next[pick.free_idx] = tbse_pkg::ST_WRITING;
                    granted                    = 1'b1;
                    gslot                      = pick.free_idx;
                end
                else if (pick.oldest_found)
                begin
                    status_next[pick.oldest_idx] = tbse_pkg::ST_WRITING;
                    granted                      = 1'b1;
                    gslot                        = pick.oldest_idx;
                end
                else
                begin
                    drop_next = drop_reg + 1'b1;
                end
            end
            tbse_pkg::CMD_PUBLISH, tbse_pkg::CMD_ABANDON:
            begin
                // only a slot currently being written may be published or abandoned
                if (sel_ok && status_reg[sel_idx] == tbse_pkg::ST_WRITING)
                begin
                    if (in_cmd_reg == tbse_pkg::CMD_PUBLISH)
                    begin
                        seq_next[sel_idx]    = tbse_pkg::SEQ_WIDTH'(in_seq_reg);
                        status_next[sel_idx] = tbse_pkg::ST_READY;
                    end
                    else
                    begin
                        status_next[sel_idx] = tbse_pkg::ST_FREE;
                    end
                end
            end
            tbse_pkg::CMD_ACQUIRE:
            begin
                // newest ready slot becomes current; old previous is handed back
                if (pick.newest_found)
                begin
                    status_next[pick.newest_idx] = tbse_pkg::ST_READING;
                    if (prev_valid_reg)
                    begin
                        status_next[prev_idx_reg] = tbse_pkg::ST_FREE;
                    end
                    prev_valid_next = cur_valid_reg;
                    prev_idx_next   = cur_idx_reg;
                    cur_valid_next  = 1'b1;
                    cur_idx_next    = pick.newest_idx;
                    fresh           = 1'b1;
                end
            end
            tbse_pkg::CMD_RELEASE:
            begin
                if (prev_valid_reg)
                begin
                    status_next[prev_idx_reg] = tbse_pkg::ST_FREE;
                    prev_valid_next           = 1'b0;
                    prev_idx_next             = '0;
                end
                if (cur_valid_reg)
                begin
                    status_next[cur_idx_reg] = tbse_pkg::ST_FREE;
                    cur_valid_next           = 1'b0;
                    cur_idx_next             = '0;
                end
            end
            default:
            begin
                // unused codes leave everything as it is
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < tbse_pkg::NUM_SLOTS; i++)
            begin
                status_reg[i] <= tbse_pkg::ST_FREE;
                seq_reg[i]    <= '0;
            end
            drop_reg       <= '0;
            prev_valid_reg <= 1'b0;
            prev_idx_reg   <= '0;
            cur_valid_reg  <= 1'b0;
            cur_idx_reg    <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                in_valid_reg <= 1'b0;
            end
            if (process)
            begin
                out_valid_reg  <= 1'b1;
                status_reg     <= status_next;
                seq_reg        <= seq_next;
                drop_reg       <= drop_next;
                prev_valid_reg <= prev_valid_next;
                prev_idx_reg   <= prev_idx_next;
                cur_valid_reg  <= cur_valid_next;
                cur_idx_reg    <= cur_idx_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg <= tbse_pkg::cmd_t'(cmd.command);
            in_sel_reg <= cmd.slot_index;
            in_seq_reg <= cmd.sequence_req;
        end
        if (process)
        begin
            out_granted_reg  <= granted;
            out_wslot_reg    <= tbse_pkg::IDX_W'(gslot);
            out_has_prev_reg <= prev_valid_next;
            out_prev_reg     <= prev_valid_next ? tbse_pkg::IDX_W'(prev_idx_next) : '0;
            out_has_cur_reg  <= cur_valid_next;
            out_cur_reg      <= cur_valid_next ? tbse_pkg::IDX_W'(cur_idx_next) : '0;
            out_fresh_reg    <= fresh;
            out_drop_reg     <= drop_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.write_granted  = out_granted_reg;
    assign res.write_slot     = out_wslot_reg;
    assign res.holds_previous = out_has_prev_reg;
    assign res.previous_slot  = out_prev_reg;
    assign res.holds_current  = out_has_cur_reg;
    assign res.current_slot   = out_cur_reg;
    assign res.new_snapshot   = out_fresh_reg;
    assign res.dropped_count  = out_drop_reg;

endmodule
